// ----- hw/rtl/i2a_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_pkg: shared types and constants of the integer to ASCII formatter
// Format kinds, job and text records passed between the front, the
// converter and the character emitter, and the ASCII codes in use.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned NUM_DIGITS = 20;
  localparam int unsigned COUNT_W    = 5;

  typedef enum logic [1:0] {
    KIND_DEC    = 2'd0,
    KIND_HEX_LO = 2'd1,
    KIND_HEX_UP = 2'd2,
    KIND_PTR    = 2'd3
  } kind_t;

  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_X       = 8'h78;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;

  // Classified item: magnitude, format and sign.
  typedef struct packed {
    logic [VALUE_W-1:0] mag;
    kind_t              kind;
    logic               neg;
  } job_t;

  // Converted item: digits least significant first, significant digit count.
  typedef struct packed {
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits;
    logic [COUNT_W-1:0]                 ndig;
    kind_t                              kind;
    logic                               neg;
  } text_t;

endpackage

// ----- hw/rtl/i2a_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_front: input side of the formatter
// Accept an item while the job queue has room, take the magnitude of a
// negative decimal value and push the classified job.
// ----------------------------------------------------------------------------
module i2a_front (
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [i2a_pkg::VALUE_W-1:0] value,
  input  logic [1:0]                 kind,
  input  logic                       q_full,
  output logic                       push,
  output i2a_pkg::job_t              push_job
);

  logic is_neg;

  assign item_stall = q_full;
  assign push       = item_valid && !q_full;

  // Only the decimal form is signed; the most negative value negates to
  // its own pattern, which read unsigned is the true magnitude.
  assign is_neg = (i2a_pkg::kind_t'(kind) == i2a_pkg::KIND_DEC) && value[i2a_pkg::VALUE_W-1];

  always_comb begin
    push_job.kind = i2a_pkg::kind_t'(kind);
    push_job.neg  = is_neg;
    push_job.mag  = is_neg ? ((~value) + {{(i2a_pkg::VALUE_W-1){1'b0}}, 1'b1}) : value;
  end

endmodule

// ----- hw/rtl/i2a_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_queue: two-entry job queue
// Decouple the front from the converter so each side can stall on its own.
// ----------------------------------------------------------------------------
module i2a_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  i2a_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output i2a_pkg::job_t pop_job,
  output logic          empty
);

  i2a_pkg::job_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- hw/rtl/i2a_conv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_conv: digit converter
// Pop a job, split the magnitude into digits (shift-and-add-3, four bits a
// cycle, for decimal; nibbles as they stand for hex), count significant
// digits and hold the text until the emitter takes it.
// ----------------------------------------------------------------------------
module i2a_conv (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  i2a_pkg::job_t  q_job,
  output logic           pop,
  input  logic           emit_ready,
  output logic           load,
  output i2a_pkg::text_t text
);

  localparam int unsigned BCD_W    = i2a_pkg::NUM_DIGITS * i2a_pkg::DIGIT_W;
  localparam int unsigned BITS_CYC = 4;
  localparam int unsigned STEPS    = i2a_pkg::VALUE_W / BITS_CYC;
  localparam int unsigned STEP_W   = $clog2(STEPS);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DABBLE = 4'b0010,
    ST_COUNT  = 4'b0100,
    ST_HOLD   = 4'b1000
  } state_t;

  state_t                                             state;
  logic [i2a_pkg::VALUE_W-1:0]                        mag;
  logic [i2a_pkg::NUM_DIGITS-1:0][i2a_pkg::DIGIT_W-1:0] bcd;
  logic [STEP_W-1:0]                                  step;
  i2a_pkg::kind_t                                     kind;
  logic                                               neg;
  logic [i2a_pkg::COUNT_W-1:0]                        ndig;

  logic [i2a_pkg::VALUE_W-1:0]                        mag_next;
  logic [i2a_pkg::NUM_DIGITS-1:0][i2a_pkg::DIGIT_W-1:0] bcd_next;
  logic [i2a_pkg::COUNT_W-1:0]                        ndig_next;

  assign pop  = (state == ST_IDLE) && !q_empty;
  assign load = (state == ST_HOLD) && emit_ready;

  always_comb begin
    text.digits = bcd;
    text.ndig   = ndig;
    text.kind   = kind;
    text.neg    = neg;
  end

  // Four shift-and-add-3 steps per cycle.
  always_comb begin
    logic [BCD_W-1:0] flat;
    bcd_next = bcd;
    mag_next = mag;
    for (int b = 0; b < BITS_CYC; b++) begin
      for (int d = 0; d < i2a_pkg::NUM_DIGITS; d++) begin
        if (bcd_next[d] >= 4'd5) begin
          bcd_next[d] = bcd_next[d] + 4'd3;
        end
      end
      flat     = {bcd_next[i2a_pkg::NUM_DIGITS-1:0]};
      flat     = {flat[BCD_W-2:0], mag_next[i2a_pkg::VALUE_W-1]};
      bcd_next = flat;
      mag_next = {mag_next[i2a_pkg::VALUE_W-2:0], 1'b0};
    end
  end

  // Highest non-zero digit sets the count; zero still prints one digit.
  always_comb begin
    ndig_next = i2a_pkg::COUNT_W'(1);
    for (int d = 0; d < i2a_pkg::NUM_DIGITS; d++) begin
      if (bcd[d] != '0) begin
        ndig_next = i2a_pkg::COUNT_W'(d + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= (q_job.kind == i2a_pkg::KIND_DEC) ? ST_DABBLE : ST_COUNT;
          end
        end
        ST_DABBLE: begin
          if (step == STEP_W'(STEPS - 1)) begin
            state <= ST_COUNT;
          end
        end
        ST_COUNT: state <= ST_HOLD;
        ST_HOLD: begin
          if (emit_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          kind <= q_job.kind;
          neg  <= q_job.neg;
          mag  <= q_job.mag;
          step <= '0;
          if (q_job.kind == i2a_pkg::KIND_DEC) begin
            bcd <= '0;
          end else begin
            bcd <= {{(BCD_W - i2a_pkg::VALUE_W){1'b0}}, q_job.mag};
          end
        end
      end
      ST_DABBLE: begin
        bcd  <= bcd_next;
        mag  <= mag_next;
        step <= step + STEP_W'(1);
      end
      ST_COUNT: ndig <= ndig_next;
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/i2a_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_emit: character emitter
// Take one converted text, send the prefix and then the digits, most
// significant first, one character a transfer through an output register.
// ----------------------------------------------------------------------------
module i2a_emit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  i2a_pkg::text_t              text,
  output logic                        ready,
  output logic                        char_valid,
  input  logic                        char_stall,
  output logic [7:0]                  char_code,
  output logic                        last_char,
  output logic [i2a_pkg::COUNT_W-1:0] char_total
);

  logic                                               busy;
  logic [i2a_pkg::NUM_DIGITS-1:0][i2a_pkg::DIGIT_W-1:0] digits;
  i2a_pkg::kind_t                                     kind;
  logic                                               neg;
  logic [1:0]                                         pre_left;
  logic [i2a_pkg::COUNT_W-1:0]                        didx;
  logic [i2a_pkg::COUNT_W-1:0]                        left;
  logic [i2a_pkg::COUNT_W-1:0]                        total;

  logic                                               advance;
  logic [1:0]                                         pre_load;
  logic [i2a_pkg::DIGIT_W-1:0]                        cur_digit;
  logic [7:0]                                         code_next;
  logic                                               last_next;

  function automatic logic [7:0] digit_ascii(input logic [3:0] d, input i2a_pkg::kind_t k);
    logic [7:0] d8;
    d8 = {4'h0, d};
    if (d < 4'd10) begin
      return i2a_pkg::CHAR_ZERO + d8;
    end else if (k == i2a_pkg::KIND_HEX_UP) begin
      return i2a_pkg::CHAR_UPPER_A + d8 - 8'd10;
    end else begin
      return i2a_pkg::CHAR_LOWER_A + d8 - 8'd10;
    end
  endfunction

  assign ready     = !busy;
  assign advance   = busy && (!char_valid || !char_stall);
  assign cur_digit = digits[didx];
  assign last_next = (left == i2a_pkg::COUNT_W'(1));

  always_comb begin
    if (text.neg) begin
      pre_load = 2'd1;
    end else if (text.kind == i2a_pkg::KIND_PTR) begin
      pre_load = 2'd2;
    end else begin
      pre_load = 2'd0;
    end
  end

  always_comb begin
    if (pre_left != 2'd0) begin
      if (neg) begin
        code_next = i2a_pkg::CHAR_MINUS;
      end else if (pre_left == 2'd2) begin
        code_next = i2a_pkg::CHAR_ZERO;
      end else begin
        code_next = i2a_pkg::CHAR_X;
      end
    end else begin
      code_next = digit_ascii(cur_digit, kind);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      char_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (advance && last_next) begin
        busy <= 1'b0;
      end
      if (advance) begin
        char_valid <= 1'b1;
      end else if (!char_stall) begin
        char_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digits   <= text.digits;
      kind     <= text.kind;
      neg      <= text.neg;
      pre_left <= pre_load;
      didx     <= text.ndig - i2a_pkg::COUNT_W'(1);
      left     <= text.ndig + {{(i2a_pkg::COUNT_W-2){1'b0}}, pre_load};
      total    <= text.ndig + {{(i2a_pkg::COUNT_W-2){1'b0}}, pre_load};
    end else if (advance) begin
      left <= left - i2a_pkg::COUNT_W'(1);
      if (pre_left != 2'd0) begin
        pre_left <= pre_left - 2'd1;
      end else begin
        didx <= didx - i2a_pkg::COUNT_W'(1);
      end
    end
    if (advance) begin
      char_code  <= code_next;
      last_char  <= last_next;
      char_total <= last_next ? total : '0;
    end
  end

endmodule

// ----- hw/rtl/integer_to_ascii_formatter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter: 64-bit integer to ASCII text
// Format one value as signed decimal, lower or upper case hex, or "0x" hex,
// and send its characters one transfer each.
// ----------------------------------------------------------------------------
// Use:
//   Item channel (item_valid/item_stall, value, kind): one value and its
//   format per transfer. Character channel (char_valid/char_stall,
//   char_code, last_char, char_total): one ASCII character per transfer,
//   most significant digit first, last_char and the character count on the
//   final character of each value (char_total is zero elsewhere).
// Flow:
//   Items pass through a two-entry job queue to the digit converter. For
//   decimal the converter pops the job, shifts in the magnitude four bits
//   at a time by shift-and-add-3, counts the digits and hands off; hex
//   skips the shifting. After hand-off the emitter goes busy and then
//   registers the first character, then one per cycle while char_stall is low.
//   The converter works on the next value while the emitter sends the
//   current one; a value has at most 20 characters.
// Reset (rst, synchronous): empty the queue, idle the converter and emitter
//   and drop any character waiting at the output.
// Stall: char_stall holds the output character; the emitter, then the
//   converter and the queue fill in turn, and item_stall rises when the
//   queue is full.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [i2a_pkg::VALUE_W-1:0] value,
  input  logic [1:0]                  kind,
  output logic                        char_valid,
  input  logic                        char_stall,
  output logic [7:0]                  char_code,
  output logic                        last_char,
  output logic [i2a_pkg::COUNT_W-1:0] char_total
);

  // Front to queue
  logic           push;
  i2a_pkg::job_t  push_job;
  logic           q_full;

  // Queue to converter
  logic           pop;
  i2a_pkg::job_t  q_job;
  logic           q_empty;

  // Converter to emitter
  logic           emit_ready;
  logic           load;
  i2a_pkg::text_t text;

  // Classify and take the magnitude of each item.
  i2a_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .value      (value),
    .kind       (kind),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  // Hold up to two classified jobs between front and back.
  i2a_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (q_job),
    .empty    (q_empty)
  );

  // Split the magnitude into digits.
  i2a_conv u_conv (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_job      (q_job),
    .pop        (pop),
    .emit_ready (emit_ready),
    .load       (load),
    .text       (text)
  );

  // Send prefix and digits, one character per transfer.
  i2a_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .text       (text),
    .ready      (emit_ready),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code),
    .last_char  (last_char),
    .char_total (char_total)
  );

endmodule
